/* design/u16u8_pkg.sv */
// Shared types, constants and the code point encoder for the UTF-16 to UTF-8 converter.
// No dependencies; used by the front, queue, back and top level modules.
package u16u8_pkg;

   localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
   localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;

   localparam int MAX_BYTES  = 6;
   localparam int CNT_W      = $clog2(MAX_BYTES + 1);
   localparam int IDX_W      = $clog2(MAX_BYTES);
   localparam int JOB_DEPTH  = 2;
   localparam int JOB_PTR_W  = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W  = $clog2(JOB_DEPTH + 1);

   // UTF-8 form of one code point, first byte in the lowest bits
   typedef struct packed {
      logic [31:0] bytes;
      logic [2:0]  len;
   } enc_type;

   // One queued job: all bytes caused by one input item
   typedef struct packed {
      logic [8*MAX_BYTES-1:0] bytes;
      logic [CNT_W-1:0]       count;
      logic                   fin;
   } job_type;

   function automatic enc_type encode_cp(input logic [20:0] cp);
      enc_type e;
      e.bytes = '0;
      e.len   = 3'd0;
      if (cp <= 21'h7F) begin
         e.bytes[7:0] = {1'b0, cp[6:0]};
         e.len        = 3'd1;
      end else if (cp <= 21'h7FF) begin
         e.bytes[7:0]  = {3'b110, cp[10:6]};
         e.bytes[15:8] = {2'b10, cp[5:0]};
         e.len         = 3'd2;
      end else if (cp <= 21'hFFFF) begin
         e.bytes[7:0]   = {4'b1110, cp[15:12]};
         e.bytes[15:8]  = {2'b10, cp[11:6]};
         e.bytes[23:16] = {2'b10, cp[5:0]};
         e.len          = 3'd3;
      end else begin
         e.bytes[7:0]   = {5'b11110, cp[20:18]};
         e.bytes[15:8]  = {2'b10, cp[17:12]};
         e.bytes[23:16] = {2'b10, cp[11:6]};
         e.bytes[31:24] = {2'b10, cp[5:0]};
         e.len          = 3'd4;
      end
      return e;
   endfunction

endpackage

/* design/u16u8_front.sv */
// Front end: accepts UTF-16 code units, tracks the held high surrogate and
// builds one job of up to six UTF-8 bytes per unit. Depends on u16u8_pkg.
module u16u8_front import u16u8_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [15:0] code_unit,
   input  logic        final_unit,
   input  logic        q_full,
   output logic        push,
   output job_type     job
);

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_bits_ff, held_bits_in;

   logic        is_high, is_low, pair, flush, hold_next, cur_emit, accept;
   logic [20:0] cur_cp;
   enc_type     cur_enc, flush_enc;
   logic [CNT_W-1:0] cur_len;

   assign is_high = code_unit inside {[HIGH_SURR_MIN:HIGH_SURR_MAX]};
   assign is_low  = code_unit inside {[LOW_SURR_MIN:LOW_SURR_MAX]};

   assign pair      = held_valid_ff && is_low;
   assign flush     = held_valid_ff && !is_low;
   assign hold_next = !pair && is_high && !final_unit;
   assign cur_emit  = !hold_next;

   assign cur_cp    = pair ? (SUPP_BASE + {1'b0, held_bits_ff, code_unit[9:0]})
                           : {5'b0, code_unit};
   assign cur_enc   = encode_cp(cur_cp);
   assign flush_enc = encode_cp({5'b0, 6'b110110, held_bits_ff});
   assign cur_len   = cur_emit ? CNT_W'(cur_enc.len) : '0;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      if (flush) begin
         // held surrogate goes first, current unit (at most three bytes) behind it
         job.bytes = {cur_enc.bytes[23:0], flush_enc.bytes[23:0]};
         job.count = CNT_W'(3) + cur_len;
      end else begin
         job.bytes = {16'b0, cur_enc.bytes};
         job.count = cur_len;
      end
      job.fin = final_unit;
   end

   assign push = accept && (job.count != '0);

   always_comb begin
      held_valid_in = held_valid_ff;
      held_bits_in  = held_bits_ff;
      if (accept) begin
         held_valid_in = hold_next;
         held_bits_in  = hold_next ? code_unit[9:0] : 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_bits_ff  <= 10'd0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_bits_ff  <= held_bits_in;
      end
   end

endmodule

/* design/u16u8_queue.sv */
// Short job queue between front and back end, built from flip-flops.
// Depends on u16u8_pkg.
module u16u8_queue import u16u8_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head_job
);

   job_type               slot_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0]  count_ff, count_in;

   assign full       = count_ff == JOB_CNT_W'(JOB_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* design/u16u8_back.sv */
// Back end: walks the head job one byte per cycle, while the output is not stalled, into a registered output stage.
// Depends on u16u8_pkg.
module u16u8_back import u16u8_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       run_last,
   output logic       stream_last
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             run_last_ff, run_last_in;
   logic             stream_last_ff, stream_last_in;
   logic             load, last;

   // load the output stage when it is empty or its transfer completes
   assign load = head_valid && (!valid_ff || out_ready);
   assign last = CNT_W'(idx_ff) == (head_job.count - 1'b1);
   assign pop  = load && last;

   always_comb begin
      idx_in         = idx_ff;
      valid_in       = valid_ff && !out_ready;
      byte_in        = byte_ff;
      run_last_in    = run_last_ff;
      stream_last_in = stream_last_ff;
      if (load) begin
         idx_in         = last ? '0 : idx_ff + 1'b1;
         valid_in       = 1'b1;
         byte_in        = head_job.bytes[{idx_ff, 3'b000} +: 8];
         run_last_in    = last;
         stream_last_in = last && head_job.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff        <= byte_in;
      run_last_ff    <= run_last_in;
      stream_last_ff <= stream_last_in;
   end

   assign out_valid   = valid_ff;
   assign out_byte    = byte_ff;
   assign run_last    = run_last_ff;
   assign stream_last = stream_last_ff;

endmodule

/* design/utf16_to_utf8_stream.sv */
// UTF-16 to UTF-8 stream converter. One code unit enters per req transfer and its UTF-8
// bytes leave one per rsp transfer: none for a held high surrogate, 1 to 4 normally,
// up to 6 when an unpaired held surrogate is flushed ahead of the unit. The byte
// serialiser sets the rate at one byte per cycle while rsp_tready does not stall it; a
// two-entry job queue lets new units be taken while earlier bytes are still going out,
// and req_tready drops only while that queue is full. rsp_tlast marks the last byte of
// each unit, rsp_tuser the last byte of the string.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
module utf16_to_utf8_stream import u16u8_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   input  logic        req_tlast,   // final_unit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser    // [0] stream_last
);

   logic    q_full, push, pop, head_valid;
   job_type job, head_job;

   u16u8_front front_i (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .code_unit  (req_tdata),
      .final_unit (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .job        (job)
   );

   u16u8_queue queue_i (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u16u8_back back_i (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .run_last    (rsp_tlast),
      .stream_last (rsp_tuser)
   );

endmodule
